FILE: design/lbmp_pkg.sv
// Shared types and constants for the Lucas binomial core.
`timescale 1ns / 1ps
package lbmp_pkg;
	localparam int TABLE_DEPTH = 65536;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int VAL_W = 16;
	localparam int ARG_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [ARG_W-1:0] arg_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		val_t  wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} tbl_port_t;
endpackage

FILE: design/lucas_binomial_mod_prime_core.sv
// Top level: table build sequencer and Lucas digit walk.
// channel | signals                     | direction
// query   | n_value k_value in_valid    | in (in_stall out)
// result  | binomial out_valid          | out (out_stall in)
// config  | prime_we prime_wdata        | in
// After a prime write, the first query builds both tables: the factorials,
// up to 33 multiplies for the Fermat power, and the inverses.
// Each query then does the two digit divisions, the table reads and three
// multiplies per base-p digit, up to 32 digits.
// One query at a time; in_stall is high while a query or result is held.
// Reset clears control only; prime resets to 2.
`timescale 1ns / 1ps
module lucas_binomial_mod_prime_core import lbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic prime_we,
	input  val_t prime_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  arg_t n_value,
	input  arg_t k_value,
	output logic out_valid,
	input  logic out_stall,
	output val_t binomial
);
	localparam logic [4:0] S_IDLE = 5'd0, S_F_MUL = 5'd1, S_F_WAIT = 5'd2,
		S_P_RD = 5'd3, S_P_RDW = 5'd4, S_P_STEP = 5'd5, S_P_WAIT = 5'd6,
		S_I_RD = 5'd7, S_I_RDW = 5'd8, S_I_MUL = 5'd9, S_I_WAIT = 5'd10,
		S_D_N = 5'd11, S_D_NW = 5'd12, S_D_K = 5'd13, S_D_KW = 5'd14,
		S_T_RD = 5'd15, S_T_RDW = 5'd16, S_T_M1 = 5'd17, S_T_W1 = 5'd18,
		S_T_M2 = 5'd19, S_T_W2 = 5'd20, S_T_M3 = 5'd21, S_T_W3 = 5'd22,
		S_OUT = 5'd23;

	logic [4:0]  state_q;
	val_t        prime_q;
	logic        ready_q;
	logic [16:0] p17;
	logic [16:0] idx_q;
	val_t        cur_q, base_q, exp_q, acc_q, term_q;
	arg_t        n_q, k_q, nq_q;
	logic [16:0] nd_q;
	logic        pw_sq_q;

	logic        mm_start, mm_done, dv_start, dv_done;
	val_t        mm_a, mm_b, mm_res;
	arg_t        dv_num, dv_quo;
	logic [16:0] dv_rem;
	tbl_port_t   fac_port, inv_port;
	val_t        fac_rd, inv_rd_a, inv_rd_b;

	assign p17 = (prime_q == '0) ? 17'd0 : {1'b0, prime_q};

	lbmp_modmul u_mul (.clk, .arst_n, .start(mm_start), .a(mm_a), .b(mm_b),
		.p(p17), .done(mm_done), .res(mm_res));
	lbmp_divmod u_div (.clk, .arst_n, .start(dv_start), .num(dv_num),
		.den(p17), .done(dv_done), .quo(dv_quo), .rem(dv_rem));
	lbmp_tables u_tbl (.clk, .fac_port, .inv_port, .fac_rdata(fac_rd),
		.inv_rdata_a(inv_rd_a), .inv_rdata_b(inv_rd_b));

	always_comb begin
		mm_start = 1'b0;
		mm_a = cur_q;
		mm_b = idx_q[VAL_W-1:0];
		dv_start = 1'b0;
		dv_num = n_q;
		fac_port = '0;
		inv_port = '0;
		case (state_q)
			S_F_MUL: begin
				mm_start = 1'b1;
				fac_port.we = (idx_q == 17'd1);
				fac_port.waddr = '0;
				fac_port.wdata = 16'd1;
			end
			S_F_WAIT: begin
				fac_port.we = mm_done;
				fac_port.waddr = idx_q[ADDR_W-1:0];
				fac_port.wdata = mm_res;
			end
			S_P_RD: fac_port.raddr_a = ADDR_W'(prime_q - 16'd1);
			S_P_STEP: begin
				mm_start = 1'b1;
				mm_a = (pw_sq_q || !exp_q[0]) ? base_q : acc_q;
				mm_b = base_q;
			end
			S_P_WAIT: begin
				inv_port.we = mm_done && pw_sq_q && exp_q == '0;
				inv_port.waddr = ADDR_W'(p17 - 17'd1);
				inv_port.wdata = acc_q;
			end
			S_I_RD: inv_port.raddr_a = idx_q[ADDR_W-1:0];
			S_I_MUL: begin
				mm_start = 1'b1;
				mm_a = cur_q;
			end
			S_I_WAIT: begin
				inv_port.we = mm_done;
				inv_port.waddr = ADDR_W'(idx_q - 17'd1);
				inv_port.wdata = mm_res;
			end
			S_D_N: dv_start = 1'b1;
			S_D_K: begin
				dv_start = 1'b1;
				dv_num = k_q;
			end
			S_T_M1: begin
				mm_start = 1'b1;
				mm_a = fac_rd;
				mm_b = inv_rd_a;
			end
			S_T_M2: begin
				mm_start = 1'b1;
				mm_a = term_q;
				mm_b = inv_rd_b;
			end
			S_T_M3: begin
				mm_start = 1'b1;
				mm_a = acc_q;
				mm_b = term_q;
			end
			default: ;
		endcase
		if (state_q inside {S_T_RD, S_T_RDW, S_T_M1, S_T_W1, S_T_M2}) begin
			fac_port.raddr_a = nd_q[ADDR_W-1:0];
			inv_port.raddr_a = idx_q[ADDR_W-1:0];
			inv_port.raddr_b = ADDR_W'(nd_q - idx_q);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign binomial  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prime_q <= 16'd2;
			ready_q <= 1'b0;
		end else begin
			if (prime_we) begin
				prime_q <= prime_wdata;
				ready_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					if (prime_q < 16'd2) begin
						state_q <= S_OUT;
					end else if (!ready_q) begin
						state_q <= S_F_MUL;
					end else begin
						state_q <= S_D_N;
					end
				end
				S_F_MUL: state_q <= S_F_WAIT;
				S_F_WAIT: if (mm_done) begin
					if (idx_q + 17'd1 >= p17) state_q <= S_P_RD;
					else state_q <= S_F_MUL;
				end
				S_P_RD: state_q <= S_P_RDW;
				S_P_RDW: state_q <= S_P_STEP;
				S_P_STEP: state_q <= S_P_WAIT;
				S_P_WAIT: if (mm_done) begin
					if (pw_sq_q && exp_q == '0) state_q <= S_I_RD;
					else state_q <= S_P_STEP;
				end
				S_I_RD: state_q <= S_I_RDW;
				S_I_RDW: state_q <= (idx_q == '0) ? S_D_N : S_I_MUL;
				S_I_MUL: state_q <= S_I_WAIT;
				S_I_WAIT: if (mm_done) state_q <= S_I_RD;
				S_D_N: state_q <= (k_q == '0) ? S_OUT : S_D_NW;
				S_D_NW: if (dv_done) state_q <= S_D_K;
				S_D_K: state_q <= S_D_KW;
				S_D_KW: if (dv_done) begin
					state_q <= (dv_rem > nd_q) ? S_OUT : S_T_RD;
				end
				S_T_RD: state_q <= S_T_RDW;
				S_T_RDW: state_q <= S_T_M1;
				S_T_M1: state_q <= S_T_W1;
				S_T_W1: if (mm_done) state_q <= S_T_M2;
				S_T_M2: state_q <= S_T_W2;
				S_T_W2: if (mm_done) state_q <= S_T_M3;
				S_T_M3: state_q <= S_T_W3;
				S_T_W3: if (mm_done) state_q <= S_D_N;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_I_RDW && idx_q == '0) ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= n_value;
				k_q   <= k_value;
				acc_q <= (prime_q < 16'd2) ? 16'd0 : 16'd1;
				idx_q <= 17'd1;
				cur_q <= 16'd1;
			end
			S_F_WAIT: if (mm_done) begin
				cur_q <= mm_res;
				idx_q <= idx_q + 17'd1;
			end
			S_P_RDW: begin
				base_q  <= fac_rd;
				acc_q   <= 16'd1;
				exp_q   <= prime_q - 16'd2;
				pw_sq_q <= 1'b0;
				if (prime_q == 16'd2) cur_q <= fac_rd;
			end
			S_P_STEP: if (!pw_sq_q && !exp_q[0]) begin
				pw_sq_q <= 1'b1;
			end
			S_P_WAIT: if (mm_done) begin
				if (pw_sq_q) begin
					base_q  <= mm_res;
					exp_q   <= exp_q >> 1;
					pw_sq_q <= 1'b0;
				end else if (exp_q[0]) begin
					acc_q   <= mm_res;
					pw_sq_q <= 1'b1;
				end else begin
					base_q  <= mm_res;
					exp_q   <= exp_q >> 1;
				end
				if (pw_sq_q && exp_q == '0) begin
					idx_q <= p17 - 17'd1;
					acc_q <= 16'd1;
				end
			end
			S_I_RDW: cur_q <= inv_rd_a;
			S_D_NW: if (dv_done) begin
				nd_q <= dv_rem;
				nq_q <= dv_quo;
			end
			S_D_KW: if (dv_done) begin
				idx_q <= dv_rem;
				k_q   <= dv_quo;
				n_q   <= nq_q;
				if (dv_rem > nd_q) acc_q <= 16'd0;
			end
			S_T_W1: if (mm_done) term_q <= mm_res;
			S_T_W2: if (mm_done) term_q <= mm_res;
			S_T_W3: if (mm_done) acc_q <= mm_res;
			default: ;
		endcase
		if (state_q == S_I_WAIT && mm_done) idx_q <= idx_q - 17'd1;
	end
endmodule

FILE: design/lbmp_modmul.sv
// Sequential shift-add modular multiplier: a*b mod p, one bit of b per cycle.
`timescale 1ns / 1ps
module lbmp_modmul import lbmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  val_t       a,
	input  val_t       b,
	input  logic [16:0] p,
	output logic       done,
	output val_t       res
);
	logic [16:0] acc_q, base_q, p_q;
	val_t        b_q;
	logic        busy_q;
	logic [17:0] acc2, base2, accs;

	always_comb begin
		accs  = {1'b0, acc_q} + {1'b0, base_q};
		if (accs >= {1'b0, p_q}) accs = accs - {1'b0, p_q};
		base2 = {base_q, 1'b0};
		if (base2 >= {1'b0, p_q}) base2 = base2 - {1'b0, p_q};
		acc2 = b_q[0] ? accs : {1'b0, acc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			p_q    <= p;
			base_q <= ({1'b0, a} >= p) ? ({1'b0, a} - p) : {1'b0, a};
			b_q    <= b;
		end else if (busy_q && b_q != '0) begin
			acc_q  <= acc2[16:0];
			base_q <= base2[16:0];
			b_q    <= b_q >> 1;
		end
	end
	assign res = acc_q[VAL_W-1:0];
endmodule

FILE: design/lbmp_divmod.sv
// Sequential restoring divider: 32-bit value by 17-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module lbmp_divmod import lbmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  arg_t        num,
	input  logic [16:0] den,
	output logic        done,
	output arg_t        quo,
	output logic [16:0] rem
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;

	assign trial = {rem, quo[ARG_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ARG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo <= num;
			rem <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem <= 17'(trial - {1'b0, den});
				quo <= {quo[ARG_W-2:0], 1'b1};
			end else begin
				rem <= trial[16:0];
				quo <= {quo[ARG_W-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: design/lbmp_tables.sv
// Factorial and inverse-factorial memories with registered read data.
`timescale 1ns / 1ps
module lbmp_tables import lbmp_pkg::*; (
	input  logic      clk,
	input  tbl_port_t fac_port,
	input  tbl_port_t inv_port,
	output val_t      fac_rdata,
	output val_t      inv_rdata_a,
	output val_t      inv_rdata_b
);
	val_t fac_mem [TABLE_DEPTH];
	val_t inv_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (fac_port.we) fac_mem[fac_port.waddr] <= fac_port.wdata;
		fac_rdata <= fac_mem[fac_port.raddr_a];
	end

	always_ff @(posedge clk) begin
		if (inv_port.we) inv_mem[inv_port.waddr] <= inv_port.wdata;
		inv_rdata_a <= inv_mem[inv_port.raddr_a];
		inv_rdata_b <= inv_mem[inv_port.raddr_b];
	end
endmodule
